FILE: hdl/dara_pkg.sv
// Shared codes, state encoding and flag structures for the resource allocator.
package dara_pkg;

    localparam logic [2:0] OP_LOAD_MAX   = 3'd0;
    localparam logic [2:0] OP_LOAD_HELD  = 3'd1;
    localparam logic [2:0] OP_LOAD_TOTAL = 3'd2;
    localparam logic [2:0] OP_REQUEST    = 3'd3;
    localparam logic [2:0] OP_RELEASE    = 3'd4;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_DENIED    = 3'd1;
    localparam logic [2:0] STATUS_OVER_NEED = 3'd2;
    localparam logic [2:0] STATUS_OVER_HELD = 3'd3;
    localparam logic [2:0] STATUS_BAD_LOAD  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_SUM_CMP,
        ST_SAFE_INIT,
        ST_SAFE,
        ST_REVERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic lt_held;
        logic gt_held;
        logic gt_max;
        logic gt_need;
        logic gt_free;
        logic fits_work;
        logic sum_over;
    } lane_flags_t;

    typedef struct packed {
        logic any_lt_held;
        logic any_gt_held;
        logic any_gt_max;
        logic any_gt_need;
        logic any_gt_free;
        logic all_fit;
        logic any_sum_over;
    } merged_t;

endpackage

FILE: hdl/dara_lane.sv
// One resource lane: compares and updates for a single resource of the addressed row.
module dara_lane #(
    parameter int AMOUNT_BITS = 8,
    parameter int SUM_W = 12
) (
    input  logic [AMOUNT_BITS-1:0] amt,
    input  logic [AMOUNT_BITS-1:0] max_v,
    input  logic [AMOUNT_BITS-1:0] held_v,
    input  logic [AMOUNT_BITS-1:0] free_v,
    input  logic [AMOUNT_BITS:0]   work_v,
    input  logic [SUM_W-1:0]       sum_v,
    output dara_pkg::lane_flags_t  flags,
    output logic [AMOUNT_BITS:0]   work_add,
    output logic [AMOUNT_BITS-1:0] held_inc,
    output logic [AMOUNT_BITS-1:0] held_dec,
    output logic [AMOUNT_BITS-1:0] free_dec,
    output logic [AMOUNT_BITS-1:0] free_inc,
    output logic [AMOUNT_BITS-1:0] free_load,
    output logic [SUM_W-1:0]       sum_add
);
    import dara_pkg::*;

    logic [AMOUNT_BITS-1:0] need;
    logic [AMOUNT_BITS+1:0] work_sum;
    logic [AMOUNT_BITS:0]   free_sum;
    logic [SUM_W-1:0]       amt_ext;
    logic [SUM_W-1:0]       load_diff;

    assign need      = (max_v > held_v) ? (max_v - held_v) : '0;
    assign amt_ext   = SUM_W'(amt);
    assign work_sum  = {1'b0, work_v} + (AMOUNT_BITS+2)'(held_v);
    assign work_add  = work_sum[AMOUNT_BITS+1] ? '1 : work_sum[AMOUNT_BITS:0];
    assign free_sum  = {1'b0, free_v} + {1'b0, amt};
    assign free_inc  = free_sum[AMOUNT_BITS] ? '1 : free_sum[AMOUNT_BITS-1:0];
    assign held_inc  = held_v + amt;
    assign held_dec  = held_v - amt;
    assign free_dec  = free_v - amt;
    assign load_diff = amt_ext - sum_v;
    assign free_load = load_diff[AMOUNT_BITS-1:0];
    assign sum_add   = sum_v + SUM_W'(held_v);

    always_comb
    begin
        flags.lt_held   = amt < held_v;
        flags.gt_held   = amt > held_v;
        flags.gt_max    = amt > max_v;
        flags.gt_need   = amt > need;
        flags.gt_free   = amt > free_v;
        flags.fits_work = {1'b0, need} <= work_v;
        flags.sum_over  = sum_v > amt_ext;
    end

endmodule

FILE: hdl/dara_merge.sv
// Merging stage that combines the per-resource lane flags into row-wide verdicts.
module dara_merge #(
    parameter int NUM_RES = 4
) (
    input  dara_pkg::lane_flags_t flags [NUM_RES],
    output dara_pkg::merged_t     merged
);
    import dara_pkg::*;

    always_comb
    begin
        merged = '0;
        merged.all_fit = 1'b1;
        for (int r = 0; r < NUM_RES; r++)
        begin
            merged.any_lt_held  = merged.any_lt_held  | flags[r].lt_held;
            merged.any_gt_held  = merged.any_gt_held  | flags[r].gt_held;
            merged.any_gt_max   = merged.any_gt_max   | flags[r].gt_max;
            merged.any_gt_need  = merged.any_gt_need  | flags[r].gt_need;
            merged.any_gt_free  = merged.any_gt_free  | flags[r].gt_free;
            merged.all_fit      = merged.all_fit      & flags[r].fits_work;
            merged.any_sum_over = merged.any_sum_over | flags[r].sum_over;
        end
    end

endmodule

FILE: hdl/deadlock_avoiding_resource_allocator_core.sv
// Top level of the banker's algorithm resource allocator with per-resource lanes.
//
//  Channel   Handshake              Payload
//  request   req_valid/req_ready    operation, process, amount_0..amount_3
//  result    rsp_valid/rsp_ready    status
//
// A request is taken only in the idle state, and the block works on one request at a time.
// Row loads and releases pass through the check and done states; a request adds a safety check.
// The safety check has a set-up state and then tests one process row per cycle; a request
// that fails it is undone in a revert state before its result is given.
// A totals load first sums the held units over all process rows and then compares the sums.
// Reset clears all tables; a finished result waits in an output register while new requests
// are taken.
module deadlock_avoiding_resource_allocator_core #(
    parameter int NUM_PROCS = 8,
    parameter int NUM_RES = 4,
    parameter int AMOUNT_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [2:0] operation,
    input  logic [2:0] process,
    input  logic [7:0] amount_0,
    input  logic [7:0] amount_1,
    input  logic [7:0] amount_2,
    input  logic [7:0] amount_3,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [2:0] status
);
    import dara_pkg::*;

    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int LW = $clog2(NUM_PROCS + 1);
    localparam int SUM_W = AMOUNT_BITS + $clog2(NUM_PROCS + 1);
    localparam int A = AMOUNT_BITS;

    state_t state_reg, state_next;

    logic [A-1:0]     max_rows_reg  [NUM_PROCS][NUM_RES];
    logic [A-1:0]     held_rows_reg [NUM_PROCS][NUM_RES];
    logic [A-1:0]     free_reg      [NUM_RES];
    logic [A-1:0]     free_next     [NUM_RES];
    logic [A:0]       work_reg      [NUM_RES];
    logic [A:0]       work_next     [NUM_RES];
    logic [SUM_W-1:0] sum_reg       [NUM_RES];
    logic [SUM_W-1:0] sum_next      [NUM_RES];
    logic [A-1:0]     amt_reg       [NUM_RES];
    logic [A-1:0]     amt_next      [NUM_RES];
    logic [A-1:0]     held_row_next [NUM_RES];
    logic [A-1:0]     amt_in        [4];

    logic [NUM_PROCS-1:0] fin_reg, fin_next;
    logic [2:0]  op_reg, op_next;
    logic [PW-1:0] proc_reg, proc_next;
    logic [PW-1:0] scan_reg, scan_next;
    logic [PW-1:0] rd_idx;
    logic [LW-1:0] left_reg, left_next;
    logic [2:0]  pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic        max_we, held_we;
    logic        accept, bad_req, row_hit, scan_last;

    lane_flags_t      flags [NUM_RES];
    merged_t          merged;
    logic [A:0]       work_add  [NUM_RES];
    logic [A-1:0]     held_inc  [NUM_RES];
    logic [A-1:0]     held_dec  [NUM_RES];
    logic [A-1:0]     free_dec  [NUM_RES];
    logic [A-1:0]     free_inc  [NUM_RES];
    logic [A-1:0]     free_load [NUM_RES];
    logic [SUM_W-1:0] sum_add   [NUM_RES];

    assign amt_in[0] = A'(amount_0);
    assign amt_in[1] = A'(amount_1);
    assign amt_in[2] = A'(amount_2);
    assign amt_in[3] = A'(amount_3);

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign bad_req   = (operation > OP_RELEASE) || (32'(process) >= NUM_PROCS);
    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign scan_last = (scan_reg == PW'(NUM_PROCS - 1));
    assign row_hit   = !fin_reg[scan_reg] && merged.all_fit;

    assign rd_idx = ((state_reg == ST_SUM) || (state_reg == ST_SAFE)) ? scan_reg : proc_reg;

    for (genvar r = 0; r < NUM_RES; r++)
    begin : g_lane
        dara_lane #(
            .AMOUNT_BITS (A),
            .SUM_W       (SUM_W)
        ) u_lane (
            .amt       (amt_reg[r]),
            .max_v     (max_rows_reg[rd_idx][r]),
            .held_v    (held_rows_reg[rd_idx][r]),
            .free_v    (free_reg[r]),
            .work_v    (work_reg[r]),
            .sum_v     (sum_reg[r]),
            .flags     (flags[r]),
            .work_add  (work_add[r]),
            .held_inc  (held_inc[r]),
            .held_dec  (held_dec[r]),
            .free_dec  (free_dec[r]),
            .free_inc  (free_inc[r]),
            .free_load (free_load[r]),
            .sum_add   (sum_add[r])
        );
    end

    dara_merge #(
        .NUM_RES (NUM_RES)
    ) u_merge (
        .flags  (flags),
        .merged (merged)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bad_req)
                        state_next = ST_DONE;
                    else if (operation == OP_LOAD_TOTAL)
                        state_next = ST_SUM;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (op_reg == OP_REQUEST && !merged.any_gt_need && !merged.any_gt_free)
                    state_next = ST_SAFE_INIT;
                else
                    state_next = ST_DONE;
            end
            ST_SUM:
            begin
                if (scan_last)
                    state_next = ST_SUM_CMP;
            end
            ST_SUM_CMP:
            begin
                state_next = merged.any_sum_over ? ST_DONE : ST_SAFE_INIT;
            end
            ST_SAFE_INIT:
            begin
                state_next = ST_SAFE;
            end
            ST_SAFE:
            begin
                if (row_hit)
                begin
                    if (left_reg == LW'(1))
                        state_next = ST_DONE;
                end
                else if (scan_last)
                begin
                    state_next = (op_reg == OP_REQUEST) ? ST_REVERT : ST_DONE;
                end
            end
            ST_REVERT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        proc_next       = proc_reg;
        scan_next       = scan_reg;
        left_next       = left_reg;
        fin_next        = fin_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        max_we          = 1'b0;
        held_we         = 1'b0;
        for (int r = 0; r < NUM_RES; r++)
        begin
            amt_next[r]      = amt_reg[r];
            free_next[r]     = free_reg[r];
            work_next[r]     = work_reg[r];
            sum_next[r]      = sum_reg[r];
            held_row_next[r] = held_inc[r];
        end

        if (out_valid_reg && rsp_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = operation;
                    proc_next = PW'(process);
                    scan_next = '0;
                    pend_next = STATUS_DENIED;
                    for (int r = 0; r < NUM_RES; r++)
                    begin
                        amt_next[r] = amt_in[r];
                        sum_next[r] = '0;
                    end
                end
            end
            ST_CHECK:
            begin
                case (op_reg)
                    OP_LOAD_MAX:
                    begin
                        if (merged.any_lt_held)
                            pend_next = STATUS_BAD_LOAD;
                        else
                        begin
                            pend_next = STATUS_OK;
                            max_we    = 1'b1;
                        end
                    end
                    OP_LOAD_HELD:
                    begin
                        if (merged.any_gt_max)
                            pend_next = STATUS_BAD_LOAD;
                        else
                        begin
                            pend_next = STATUS_OK;
                            held_we   = 1'b1;
                            for (int r = 0; r < NUM_RES; r++)
                                held_row_next[r] = amt_reg[r];
                        end
                    end
                    OP_REQUEST:
                    begin
                        if (merged.any_gt_need)
                            pend_next = STATUS_OVER_NEED;
                        else if (merged.any_gt_free)
                            pend_next = STATUS_DENIED;
                        else
                        begin
                            held_we = 1'b1;
                            for (int r = 0; r < NUM_RES; r++)
                            begin
                                held_row_next[r] = held_inc[r];
                                free_next[r]     = free_dec[r];
                            end
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (merged.any_gt_held)
                            pend_next = STATUS_OVER_HELD;
                        else
                        begin
                            pend_next = STATUS_OK;
                            held_we   = 1'b1;
                            for (int r = 0; r < NUM_RES; r++)
                            begin
                                held_row_next[r] = held_dec[r];
                                free_next[r]     = free_inc[r];
                            end
                        end
                    end
                    default:
                    begin
                        pend_next = STATUS_DENIED;
                    end
                endcase
            end
            ST_SUM:
            begin
                for (int r = 0; r < NUM_RES; r++)
                    sum_next[r] = sum_add[r];
                if (!scan_last)
                    scan_next = scan_reg + PW'(1);
            end
            ST_SUM_CMP:
            begin
                if (merged.any_sum_over)
                    pend_next = STATUS_BAD_LOAD;
                else
                begin
                    for (int r = 0; r < NUM_RES; r++)
                        free_next[r] = free_load[r];
                end
            end
            ST_SAFE_INIT:
            begin
                scan_next = '0;
                left_next = LW'(NUM_PROCS);
                fin_next  = '0;
                for (int r = 0; r < NUM_RES; r++)
                    work_next[r] = {1'b0, free_reg[r]};
            end
            ST_SAFE:
            begin
                if (row_hit)
                begin
                    fin_next[scan_reg] = 1'b1;
                    left_next = left_reg - LW'(1);
                    scan_next = '0;
                    for (int r = 0; r < NUM_RES; r++)
                        work_next[r] = work_add[r];
                    if (left_reg == LW'(1))
                        pend_next = STATUS_OK;
                end
                else if (scan_last)
                    pend_next = STATUS_DENIED;
                else
                    scan_next = scan_reg + PW'(1);
            end
            ST_REVERT:
            begin
                pend_next = STATUS_DENIED;
                held_we   = 1'b1;
                for (int r = 0; r < NUM_RES; r++)
                begin
                    held_row_next[r] = held_dec[r];
                    free_next[r]     = free_inc[r];
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                end
            end
            default:
            begin
                pend_next = STATUS_DENIED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                for (int r = 0; r < NUM_RES; r++)
                begin
                    max_rows_reg[p][r]  <= '0;
                    held_rows_reg[p][r] <= '0;
                end
            end
            for (int r = 0; r < NUM_RES; r++)
                free_reg[r] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int r = 0; r < NUM_RES; r++)
            begin
                free_reg[r] <= free_next[r];
                if (max_we)
                    max_rows_reg[proc_reg][r] <= amt_reg[r];
                if (held_we)
                    held_rows_reg[proc_reg][r] <= held_row_next[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        proc_reg       <= proc_next;
        scan_reg       <= scan_next;
        left_reg       <= left_next;
        fin_reg        <= fin_next;
        pend_reg       <= pend_next;
        out_status_reg <= out_status_next;
        for (int r = 0; r < NUM_RES; r++)
        begin
            amt_reg[r]  <= amt_next[r];
            work_reg[r] <= work_next[r];
            sum_reg[r]  <= sum_next[r];
        end
    end

endmodule

FILE: dv/tb_deadlock_avoiding_resource_allocator_core.sv
// Self-checking testbench for the banker's algorithm resource allocator core.
`timescale 1ns / 1ps

module tb_deadlock_avoiding_resource_allocator_core;
    import dara_pkg::*;

    localparam int NP = 8;
    localparam int NR = 4;
    localparam int CYC = 4;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] proc;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
    } alloc_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic [2:0] operation = '0;
    logic [2:0] process = '0;
    logic [7:0] amount_0 = '0;
    logic [7:0] amount_1 = '0;
    logic [7:0] amount_2 = '0;
    logic [7:0] amount_3 = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    logic [2:0] status;

    deadlock_avoiding_resource_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .operation(operation), .process(process),
        .amount_0(amount_0), .amount_1(amount_1),
        .amount_2(amount_2), .amount_3(amount_3),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status)
    );

    always
    begin
        #(CYC / 2) clk = 1'b1;
        #(CYC / 2) clk = 1'b0;
    end

    int unsigned mx_tab [NP][NR];
    int unsigned hd_tab [NP][NR];
    int unsigned fr_vec [NR];

    alloc_req_t pending_reqs [$];
    logic [2:0] expected_status [$];
    int errors = 0;
    int send_idle_pct = 22;
    int recv_idle_pct = 62;
    bit recv_hold = 1'b0;
    bit send_pause = 1'b0;

    function automatic int unsigned need_units(int p, int r);
        return mx_tab[p][r] > hd_tab[p][r] ? mx_tab[p][r] - hd_tab[p][r] : 0;
    endfunction

    function automatic bit state_is_safe();
        int unsigned wk [NR];
        bit fin [NP];
        int left;
        bit found;
        bit fits;
        left = NP;
        for (int r = 0; r < NR; r++) wk[r] = fr_vec[r];
        for (int p = 0; p < NP; p++) fin[p] = 1'b0;
        while (left != 0)
        begin
            found = 1'b0;
            for (int p = 0; p < NP && !found; p++)
            begin
                if (!fin[p])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < NR; r++)
                        if (need_units(p, r) > wk[r]) fits = 1'b0;
                    if (fits)
                    begin
                        fin[p] = 1'b1;
                        left--;
                        found = 1'b1;
                        for (int r = 0; r < NR; r++)
                        begin
                            wk[r] = wk[r] + hd_tab[p][r];
                            if (wk[r] > 511) wk[r] = 511;
                        end
                    end
                end
            end
            if (!found) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [2:0] allocate_step(alloc_req_t q);
        int unsigned am [NR];
        int unsigned sm [NR];
        int p;
        am[0] = q.a0; am[1] = q.a1; am[2] = q.a2; am[3] = q.a3;
        p = q.proc;
        if (q.op > OP_RELEASE || p >= NP) return STATUS_DENIED;
        case (q.op)
            OP_LOAD_MAX:
            begin
                for (int r = 0; r < NR; r++)
                    if (am[r] < hd_tab[p][r]) return STATUS_BAD_LOAD;
                for (int r = 0; r < NR; r++) mx_tab[p][r] = am[r];
                return STATUS_OK;
            end
            OP_LOAD_HELD:
            begin
                for (int r = 0; r < NR; r++)
                    if (am[r] > mx_tab[p][r]) return STATUS_BAD_LOAD;
                for (int r = 0; r < NR; r++) hd_tab[p][r] = am[r];
                return STATUS_OK;
            end
            OP_LOAD_TOTAL:
            begin
                for (int r = 0; r < NR; r++)
                begin
                    sm[r] = 0;
                    for (int k = 0; k < NP; k++) sm[r] += hd_tab[k][r];
                    if (sm[r] > am[r]) return STATUS_BAD_LOAD;
                end
                for (int r = 0; r < NR; r++) fr_vec[r] = am[r] - sm[r];
                return state_is_safe() ? STATUS_OK : STATUS_DENIED;
            end
            OP_REQUEST:
            begin
                for (int r = 0; r < NR; r++)
                    if (am[r] > need_units(p, r)) return STATUS_OVER_NEED;
                for (int r = 0; r < NR; r++)
                    if (am[r] > fr_vec[r]) return STATUS_DENIED;
                for (int r = 0; r < NR; r++)
                begin
                    fr_vec[r] -= am[r];
                    hd_tab[p][r] += am[r];
                end
                if (state_is_safe()) return STATUS_OK;
                for (int r = 0; r < NR; r++)
                begin
                    fr_vec[r] += am[r];
                    hd_tab[p][r] -= am[r];
                end
                return STATUS_DENIED;
            end
            default:
            begin
                for (int r = 0; r < NR; r++)
                    if (am[r] > hd_tab[p][r]) return STATUS_OVER_HELD;
                for (int r = 0; r < NR; r++)
                begin
                    fr_vec[r] = fr_vec[r] + am[r];
                    if (fr_vec[r] > 255) fr_vec[r] = 255;
                    hd_tab[p][r] -= am[r];
                end
                return STATUS_OK;
            end
        endcase
    endfunction

    // Driver: presents requests from the pending queue, holding each until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_status.push_back(allocate_step(pending_reqs.pop_front()));
            if ((!req_valid || req_ready) && !send_pause && pending_reqs.size() > 0)
            begin
                if ($urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    operation <= pending_reqs[0].op;
                    process <= pending_reqs[0].proc;
                    amount_0 <= pending_reqs[0].a0;
                    amount_1 <= pending_reqs[0].a1;
                    amount_2 <= pending_reqs[0].a2;
                    amount_3 <= pending_reqs[0].a3;
                end
                else
                    req_valid <= 1'b0;
            end
            else if (req_valid && req_ready)
                req_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, status);
                    errors++;
                end
                else if (expected_status[0] !== status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, expected_status[0], status);
                    errors++;
                    void'(expected_status.pop_front());
                end
                else
                    void'(expected_status.pop_front());
            end
            rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic alloc_req_t make_req(logic [2:0] op, logic [2:0] p,
                                            logic [7:0] a0, logic [7:0] a1,
                                            logic [7:0] a2, logic [7:0] a3);
        alloc_req_t q;
        q.op = op; q.proc = p; q.a0 = a0; q.a1 = a1; q.a2 = a2; q.a3 = a3;
        return q;
    endfunction

    function automatic logic [7:0] rnd_amt(int unsigned hi);
        int k;
        k = $urandom_range(9);
        if (k == 0) return 8'd0;
        if (k == 1) return 8'd255;
        if (k == 2) return 8'($urandom);
        return 8'($urandom_range(hi));
    endfunction

    task automatic add_random(int n);
        int k;
        logic [2:0] op;
        int unsigned hi;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            hi = $urandom_range(1) ? 6 : 40;
            if (k < 5) op = 3'($urandom_range(7, 5));
            else if (k < 20) op = OP_LOAD_MAX;
            else if (k < 30) op = OP_LOAD_HELD;
            else if (k < 42) op = OP_LOAD_TOTAL;
            else if (k < 75) op = OP_REQUEST;
            else op = OP_RELEASE;
            if (op == OP_LOAD_TOTAL && $urandom_range(3) != 0)
                pending_reqs.push_back(make_req(op, 3'($urandom),
                    8'($urandom_range(255, 60)), 8'($urandom_range(255, 60)),
                    8'($urandom_range(255, 60)), 8'($urandom_range(255, 60))));
            else
                pending_reqs.push_back(make_req(op, 3'($urandom), rnd_amt(hi),
                    rnd_amt(hi), rnd_amt(hi), rnd_amt(hi)));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: build a small system, then hit each status.
        for (int p = 0; p < 4; p++)
            pending_reqs.push_back(make_req(OP_LOAD_MAX, 3'(p), 8'd10, 8'd10, 8'd10, 8'd10));
        pending_reqs.push_back(make_req(OP_LOAD_MAX, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_reqs.push_back(make_req(OP_LOAD_HELD, 3'd0, 8'd5, 8'd5, 8'd5, 8'd5));
        pending_reqs.push_back(make_req(OP_LOAD_HELD, 3'd1, 8'd11, 8'd0, 8'd0, 8'd0));
        pending_reqs.push_back(make_req(OP_LOAD_MAX, 3'd0, 8'd4, 8'd10, 8'd10, 8'd10));
        pending_reqs.push_back(make_req(OP_LOAD_TOTAL, 3'd0, 8'd4, 8'd9, 8'd9, 8'd9));
        pending_reqs.push_back(make_req(OP_LOAD_TOTAL, 3'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_reqs.push_back(make_req(OP_LOAD_TOTAL, 3'd3, 8'd8, 8'd8, 8'd8, 8'd8));
        pending_reqs.push_back(make_req(OP_LOAD_TOTAL, 3'd5, 8'd20, 8'd20, 8'd20, 8'd20));
        pending_reqs.push_back(make_req(OP_REQUEST, 3'd1, 8'd11, 8'd0, 8'd0, 8'd0));
        pending_reqs.push_back(make_req(OP_REQUEST, 3'd7, 8'd200, 8'd0, 8'd0, 8'd0));
        pending_reqs.push_back(make_req(OP_REQUEST, 3'd0, 8'd5, 8'd5, 8'd5, 8'd5));
        pending_reqs.push_back(make_req(OP_REQUEST, 3'd7, 8'd10, 8'd10, 8'd10, 8'd10));
        pending_reqs.push_back(make_req(OP_REQUEST, 3'd1, 8'd3, 8'd2, 8'd1, 8'd0));
        pending_reqs.push_back(make_req(OP_RELEASE, 3'd0, 8'd6, 8'd0, 8'd0, 8'd0));
        pending_reqs.push_back(make_req(OP_RELEASE, 3'd0, 8'd5, 8'd5, 8'd5, 8'd5));
        pending_reqs.push_back(make_req(OP_LOAD_MAX, 3'd6, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_reqs.push_back(make_req(OP_LOAD_HELD, 3'd6, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_reqs.push_back(make_req(OP_RELEASE, 3'd6, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_reqs.push_back(make_req(3'd5, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        pending_reqs.push_back(make_req(3'd7, 3'd7, 8'd255, 8'd255, 8'd255, 8'd255));
        wait_drained();

        add_random(530);
        wait_drained();

        send_idle_pct = 62;
        recv_idle_pct = 22;
        recv_hold = 1'b1;
        add_random(530);
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(270);
        while (pending_reqs.size() > 135) @(posedge clk);
        send_pause = 1'b1;
        while (expected_status.size() != 0 || req_valid) @(posedge clk);
        send_pause = 1'b0;
        add_random(270);
        wait_drained();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(CYC * 3000000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/dara_pkg.sv
hdl/dara_lane.sv
hdl/dara_merge.sv
hdl/deadlock_avoiding_resource_allocator_core.sv
dv/tb_deadlock_avoiding_resource_allocator_core.sv
